[hdl/sddc_pkg.sv]
// Shared types, character codes and the seven-segment table of the serial digit display controller.
package sddc_pkg;

   // Store geometry: the digit store always holds eight entries.
   localparam int STORE_DEPTH        = 8;
   localparam int IDX_W              = 3;
   localparam int NUM_DIGITS_DEFAULT = 8;

   // Event kinds on the request channel.
   localparam logic [1:0] OP_RX_BYTE  = 2'd0;
   localparam logic [1:0] OP_TX_READY = 2'd1;
   localparam logic [1:0] OP_SCAN     = 2'd2;

   // Result kinds on the response channel.
   localparam logic RSP_TX_BYTE = 1'b0;
   localparam logic RSP_DIGIT   = 1'b1;

   // Received and transmitted character codes.
   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_T  = 8'h54;
   localparam logic [7:0] CHAR_N  = 8'h4E;
   localparam logic [7:0] CHAR_C  = 8'h43;
   localparam logic [7:0] CHAR_O  = 8'h4F;
   localparam logic [7:0] CHAR_K  = 8'h4B;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Blank digit code and the all-off segment pattern.
   localparam logic [3:0] BLANK_CODE = 4'd10;
   localparam logic [7:0] SEG_BLANK  = 8'hFF;

   // Commands passed from the front end to the back end.
   typedef enum logic [2:0] {
      CMD_BLANK,
      CMD_HOME,
      CMD_STORE,
      CMD_REPLY,
      CMD_TX_READY,
      CMD_SCAN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   nibble;
   } cmd_type;

   // Common-anode pattern of one stored code; codes above nine show blank.
   function automatic logic [7:0] seg_pattern(input logic [3:0] code);
      logic [7:0] pat;
      case (code)
         4'd0:    pat = 8'hC0;
         4'd1:    pat = 8'hF9;
         4'd2:    pat = 8'hA4;
         4'd3:    pat = 8'hB0;
         4'd4:    pat = 8'h99;
         4'd5:    pat = 8'h92;
         4'd6:    pat = 8'h82;
         4'd7:    pat = 8'hF8;
         4'd8:    pat = 8'h80;
         4'd9:    pat = 8'h90;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

[hdl/sddc_front.sv]
// Front end: accepts events, sorts them into commands and queues them for the back end.
module sddc_front
   import sddc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_tuser,   // [1:0] op
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec_cmd;
   logic       dec_keep;
   logic       push;
   logic       pop;

   // Classify the event; ignored bytes and the unused kind are dropped here.
   always_comb begin
      dec_keep       = 1'b1;
      dec_cmd.kind   = CMD_SCAN;
      dec_cmd.nibble = req_tdata[3:0];
      case (req_tuser)
         OP_RX_BYTE: begin
            case (req_tdata)
               CHAR_A, CHAR_CR, CHAR_T: dec_keep = 1'b0;
               CHAR_N:  dec_cmd.kind = CMD_HOME;
               CHAR_C:  dec_cmd.kind = CMD_BLANK;
               CHAR_LF: dec_cmd.kind = CMD_REPLY;
               default: dec_cmd.kind = CMD_STORE;
            endcase
         end
         OP_TX_READY: dec_cmd.kind = CMD_TX_READY;
         OP_SCAN:     dec_cmd.kind = CMD_SCAN;
         default:     dec_keep = 1'b0;
      endcase
   end

   // Two-entry queue between the two halves.
   assign req_tready = (count_ff != 2'd2);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready && dec_keep;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

[hdl/sddc_back.sv]
// Back end: executes queued commands on the digit store and reply state, drives the results.
module sddc_back
   import sddc_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] kind
   output logic [23:0] rsp_tdata,   // [7:0] tx_byte, [15:8] digit_select, [23:16] segments
   output logic        rsp_tlast    // last
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(NUM_DIGITS - 1);
   localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(1);

   state_type        state_ff, state_in;
   logic [3:0]       store_ff [STORE_DEPTH];
   logic [3:0]       store_in [STORE_DEPTH];
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [7:0]       last_sent_ff, last_sent_in;
   logic             tx_active_ff, tx_active_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_tx_ff, rsp_tx_in;
   logic [7:0]       rsp_sel_ff, rsp_sel_in;
   logic [7:0]       rsp_seg_ff, rsp_seg_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             out_free;
   logic             send;
   logic [7:0]       send_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmd_ready  = (state_ff == ST_IDLE) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_seg_ff, rsp_sel_ff, rsp_tx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Next-state logic for command execution and the digit scan.
   always_comb begin
      state_in       = state_ff;
      store_in       = store_ff;
      write_index_in = write_index_ff;
      scan_idx_in    = scan_idx_ff;
      last_sent_in   = last_sent_ff;
      tx_active_in   = tx_active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_tx_in      = rsp_tx_ff;
      rsp_sel_in     = rsp_sel_ff;
      rsp_seg_in     = rsp_seg_ff;
      rsp_last_in    = rsp_last_ff;
      send           = 1'b0;
      send_byte      = CHAR_O;

      if (cmd_valid && cmd_ready) begin
         case (cmd.kind)
            CMD_BLANK: begin
               for (int i = 0; i < STORE_DEPTH; i++) begin
                  store_in[i] = BLANK_CODE;
               end
            end
            CMD_HOME: begin
               for (int i = 0; i < STORE_DEPTH; i++) begin
                  store_in[i] = BLANK_CODE;
               end
               write_index_in = '0;
            end
            CMD_STORE: begin
               store_in[write_index_ff] = cmd.nibble;
               if (write_index_ff == LAST_DIGIT) begin
                  write_index_in = '0;
               end else begin
                  write_index_in = write_index_ff + IDX_ONE;
               end
            end
            CMD_REPLY: begin
               tx_active_in = 1'b1;
               send         = 1'b1;
               send_byte    = CHAR_O;
            end
            CMD_TX_READY: begin
               if (tx_active_ff) begin
                  case (last_sent_ff)
                     CHAR_O: begin
                        send      = 1'b1;
                        send_byte = CHAR_K;
                     end
                     CHAR_K: begin
                        send      = 1'b1;
                        send_byte = CHAR_CR;
                     end
                     CHAR_CR: begin
                        send      = 1'b1;
                        send_byte = CHAR_LF;
                     end
                     CHAR_LF: tx_active_in = 1'b0;
                     default: ;
                  endcase
               end
            end
            CMD_SCAN: begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
            default: ;
         endcase
      end

      // A reply byte goes out as a single-result run.
      if (send) begin
         last_sent_in = send_byte;
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RSP_TX_BYTE;
         rsp_tx_in    = send_byte;
         rsp_sel_in   = 8'h00;
         rsp_seg_in   = SEG_BLANK;
         rsp_last_in  = 1'b1;
      end

      // One digit per transfer slot while scanning.
      if (state_ff == ST_SCAN && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = RSP_DIGIT;
         rsp_tx_in    = 8'h00;
         rsp_sel_in   = 8'h01 << scan_idx_ff;
         rsp_seg_in   = seg_pattern(store_ff[scan_idx_ff]);
         if (scan_idx_ff == LAST_DIGIT) begin
            rsp_last_in = 1'b1;
            state_in    = ST_IDLE;
         end else begin
            rsp_last_in = 1'b0;
            scan_idx_in = scan_idx_ff + IDX_ONE;
         end
      end
   end

   // State, store and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= BLANK_CODE;
         end
         write_index_ff <= '0;
         scan_idx_ff    <= '0;
         last_sent_ff   <= 8'h00;
         tx_active_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         store_ff       <= store_in;
         write_index_ff <= write_index_in;
         scan_idx_ff    <= scan_idx_in;
         last_sent_ff   <= last_sent_in;
         tx_active_ff   <= tx_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_tx_ff   <= rsp_tx_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[hdl/serial_digit_display_controller_core.sv]
// Top level of the serial digit display controller.
//
// The request channel carries one event per transfer: tuser holds the event kind
// (received byte, transmitter ready, scan tick) and tdata the received byte.
// The response channel carries transmit bytes and digit drives; tuser tells which,
// and tlast marks the final result of the run an event caused.
// Accepted events are decoded and placed in a two-entry queue; the back end takes
// one command from it when it is idle and its output register is free.
// A reply byte's command passes through the queue, then the byte is registered in the
// output register and offered on the response channel; a stall can hold either step.
// A scan tick yields NUM_DIGITS digit results back to back unless the receiver
// stalls; the back end takes the command, then drives one digit per slot until the last.
// Other events are executed as their command is taken; each gives at most one result.
// While the receiver stalls the output register holds its result, the back end
// waits, and the queue keeps taking events until both entries are filled.
// Reset blanks all eight digits, homes the write index, ends any reply and empties
// the queue and output register.
module serial_digit_display_controller_core
   import sddc_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] op
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] kind
   output logic [23:0] rsp_tdata,   // [7:0] tx_byte, [15:8] digit_select, [23:16] segments
   output logic        rsp_tlast    // last
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // Decode and queue incoming events.
   sddc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // Execute commands and drive results.
   sddc_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[verif/tb_serial_digit_display_controller_core.sv]
// Self-checking testbench for the serial digit display controller core.
`timescale 1ns / 100ps

module tb_serial_digit_display_controller_core;
   import sddc_pkg::*;

   // Digits driven per scan tick; the block runs with its default size.
   localparam int SCAN_DIGITS = NUM_DIGITS_DEFAULT;

   // Active-low patterns for codes 0 to 9, code 0 in the lowest byte.
   localparam logic [79:0] SEG_ROM = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                      8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

   // One event on the request channel; hold_for_drain stalls it until all
   // earlier results have arrived.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic       hold_for_drain;
   } panel_event_type;

   // One result on the response channel.
   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       last;
   } panel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = OP_RX_BYTE;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   // Queues of events still to send and of results still to arrive.
   panel_event_type  event_queue[$];
   panel_result_type awaited_results[$];

   // Shadow state of the display and reply logic.
   logic [3:0] shadow_digits [0:STORE_DEPTH-1];
   logic [2:0] shadow_wr_idx;
   logic [7:0] shadow_last_tx;
   logic       shadow_reply_on;

   // Transfer flags from the previous rising edge.
   logic req_accepted = 1'b0;
   logic rsp_accepted = 1'b0;

   int fail_count = 0;
   int gap_left   = 0;
   int stall_left = 0;
   int feed_count = 0;
   int sink_count = 0;
   bit feed_burst = 1'b0;
   bit sink_burst = 1'b0;

   serial_digit_display_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Blank every entry of the shadow store.
   task automatic blank_digits();
      for (int i = 0; i < STORE_DEPTH; i++) begin
         shadow_digits[i] = BLANK_CODE;
      end
   endtask

   // Queue one reply byte and remember it as the last one sent.
   task automatic expect_reply_byte(input logic [7:0] ch);
      panel_result_type r;
      r.kind         = RSP_TX_BYTE;
      r.tx_byte      = ch;
      r.digit_select = 8'h00;
      r.segments     = SEG_BLANK;
      r.last         = 1'b1;
      awaited_results.push_back(r);
      shadow_last_tx = ch;
   endtask

   // Update the shadow state for one accepted event and queue its results.
   task automatic predict_event(input logic [1:0] op, input logic [7:0] ch);
      panel_result_type r;
      logic [3:0]       code;
      case (op)
         OP_RX_BYTE: begin
            case (ch)
               CHAR_A, CHAR_CR, CHAR_T: begin
               end
               CHAR_N: begin
                  shadow_wr_idx = '0;
                  blank_digits();
               end
               CHAR_C: begin
                  blank_digits();
               end
               CHAR_LF: begin
                  shadow_reply_on = 1'b1;
                  expect_reply_byte(CHAR_O);
               end
               default: begin
                  // Any other byte is a digit: keep its low nibble.
                  shadow_digits[shadow_wr_idx] = ch[3:0];
                  if (int'(shadow_wr_idx) + 1 >= SCAN_DIGITS) begin
                     shadow_wr_idx = '0;
                  end else begin
                     shadow_wr_idx = shadow_wr_idx + 3'd1;
                  end
               end
            endcase
         end
         OP_TX_READY: begin
            if (shadow_reply_on) begin
               case (shadow_last_tx)
                  CHAR_O:  expect_reply_byte(CHAR_K);
                  CHAR_K:  expect_reply_byte(CHAR_CR);
                  CHAR_CR: expect_reply_byte(CHAR_LF);
                  CHAR_LF: shadow_reply_on = 1'b0;
                  default: begin
                  end
               endcase
            end
         end
         OP_SCAN: begin
            for (int i = 0; i < SCAN_DIGITS; i++) begin
               code           = shadow_digits[i];
               r.kind         = RSP_DIGIT;
               r.tx_byte      = 8'h00;
               r.digit_select = 8'(1 << i);
               r.segments     = (code < 4'd10) ? SEG_ROM[code*8 +: 8] : SEG_BLANK;
               r.last         = (i == SCAN_DIGITS - 1);
               awaited_results.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Compare one field of a result and report it when it differs.
   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Sample both channels at the rising edge; check results, then predict.
   always @(posedge clock) begin : watch_ports
      panel_result_type got;
      panel_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         rsp_accepted <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.kind         = rsp_tuser;
            got.tx_byte      = rsp_tdata[7:0];
            got.digit_select = rsp_tdata[15:8];
            got.segments     = rsp_tdata[23:16];
            got.last         = rsp_tlast;
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 8'(want.kind), 8'(got.kind));
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("digit_select", want.digit_select, got.digit_select);
               check_field("segments", want.segments, got.segments);
               check_field("last", 8'(want.last), 8'(got.last));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_event(req_tuser, req_tdata);
         end
      end
   end

   // Request driver: present queued events at the falling edge with random gaps.
   always @(negedge clock) begin : drive_events
      panel_event_type nxt;
      logic            valid_n;
      valid_n = req_tvalid;
      if (reset) begin
         valid_n = 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         valid_n = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (event_queue.size() != 0 &&
                      !(event_queue[0].hold_for_drain && awaited_results.size() != 0)) begin
            nxt = event_queue.pop_front();
            req_tuser <= nxt.op;
            req_tdata <= nxt.rx_byte;
            valid_n = 1'b1;
            // Switch between bursts without gaps and gappy stretches now and then.
            if (feed_count % 48 == 0) begin
               feed_burst = ($urandom_range(0, 2) == 0);
            end
            feed_count++;
            gap_left = feed_burst ? 0 : $urandom_range(0, 3);
         end
      end
      req_tvalid <= valid_n;
   end

   // Result sink: after each transfer, stall for a random number of cycles.
   always @(negedge clock) begin : drain_results
      logic ready_n;
      if (rsp_accepted) begin
         if (sink_count % 40 == 0) begin
            sink_burst = ($urandom_range(0, 2) == 0);
         end
         sink_count++;
         stall_left = sink_burst ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
         ready_n = 1'b0;
         stall_left--;
      end else begin
         ready_n = 1'b1;
      end
      rsp_tready <= ready_n;
   end

   // Append one event to the stimulus queue.
   task automatic add_event(input logic [1:0] op, input logic [7:0] ch,
                            input logic hold = 1'b0);
      panel_event_type e;
      e.op             = op;
      e.rx_byte        = ch;
      e.hold_for_drain = hold;
      event_queue.push_back(e);
   endtask

   // Build the stimulus, run it and judge the outcome.
   initial begin : run_test
      logic [7:0] cmd_set [0:4];
      int         n_items;
      int         pick;
      int         run_len;

      shadow_wr_idx   = '0;
      shadow_last_tx  = 8'h00;
      shadow_reply_on = 1'b0;
      blank_digits();

      cmd_set[0] = CHAR_A;
      cmd_set[1] = CHAR_CR;
      cmd_set[2] = CHAR_T;
      cmd_set[3] = CHAR_N;
      cmd_set[4] = CHAR_C;

      // Directed part: blank scan, idle ready, unused kind, digits with wrap.
      add_event(OP_SCAN, 8'h00);
      add_event(OP_TX_READY, 8'hFF);
      add_event(2'd3, 8'hFF);
      add_event(OP_RX_BYTE, 8'h00);
      add_event(OP_RX_BYTE, 8'h39);
      add_event(OP_RX_BYTE, 8'hFF);
      add_event(OP_RX_BYTE, 8'h3A);
      add_event(OP_RX_BYTE, 8'h85);
      add_event(OP_RX_BYTE, 8'h17);
      add_event(OP_RX_BYTE, 8'hE4);
      add_event(OP_RX_BYTE, 8'h62);
      add_event(OP_RX_BYTE, 8'h33);
      // Ignored bytes must leave the store as it is.
      add_event(OP_RX_BYTE, CHAR_A);
      add_event(OP_RX_BYTE, CHAR_CR);
      add_event(OP_RX_BYTE, CHAR_T);
      add_event(OP_SCAN, 8'h00);
      // Clear keeps the write index; home resets it.
      add_event(OP_RX_BYTE, CHAR_C);
      add_event(OP_SCAN, 8'h00, 1'b1);
      add_event(OP_RX_BYTE, CHAR_N);
      // Reply, restarted by a second line feed, then run to its end.
      add_event(OP_RX_BYTE, CHAR_LF);
      add_event(OP_TX_READY, 8'h00);
      add_event(OP_RX_BYTE, CHAR_LF);
      for (int i = 0; i < 5; i++) begin
         add_event(OP_TX_READY, 8'(i));
      end

      // Random part: mostly well-formed digit runs, replies and scans.
      n_items = 0;
      while (n_items < 420) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            run_len = $urandom_range(1, 9);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(0, 1) == 0) begin
                  add_event(OP_RX_BYTE, 8'h30 + 8'($urandom_range(0, 9)));
               end else begin
                  add_event(OP_RX_BYTE, 8'($urandom_range(0, 255)));
               end
            end
            n_items += run_len;
         end else if (pick < 48) begin
            add_event(OP_RX_BYTE, cmd_set[$urandom_range(0, 4)]);
            n_items++;
         end else if (pick < 63) begin
            run_len = $urandom_range(2, 5);
            add_event(OP_RX_BYTE, CHAR_LF, ($urandom_range(0, 9) == 0));
            for (int i = 0; i < run_len; i++) begin
               add_event(OP_TX_READY, 8'($urandom_range(0, 255)));
            end
            n_items += run_len + 1;
         end else if (pick < 70) begin
            add_event(OP_TX_READY, 8'($urandom_range(0, 255)));
            n_items++;
         end else if (pick < 92) begin
            add_event(OP_SCAN, 8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
            n_items++;
         end else begin
            add_event(2'd3, 8'($urandom_range(0, 255)));
            n_items++;
         end
      end

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every event to be taken, every result to arrive, then a tail.
      while (event_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
hdl/sddc_pkg.sv
hdl/sddc_front.sv
hdl/sddc_back.sv
hdl/serial_digit_display_controller_core.sv
verif/tb_serial_digit_display_controller_core.sv
